@@ rtl/core/hcb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared types and constants of the Huffman code builder: action and status
// codes, datapath operation codes and the controller/datapath link structs.
// ----------------------------------------------------------------------------
package hcb_pkg;

	// Field widths of the channels
	localparam int ACTION_BITS = 2;
	localparam int SYMBOL_BITS = 8;
	localparam int FREQ_PORT_BITS = 24;
	localparam int STATUS_BITS = 2;
	localparam int CHUNK_BITS = 64;
	localparam int CHUNK_IDX_BITS = 2;
	localparam int CODE_LEN_BITS = 8;

	// Internal widths
	localparam int WEIGHT_BITS = 32;
	localparam int CODE_BITS = 256;
	localparam int LEN_BITS = 9;

	// Input actions
	localparam logic [ACTION_BITS-1:0] ACT_LOAD = 2'd0;
	localparam logic [ACTION_BITS-1:0] ACT_BUILD = 2'd1;
	localparam logic [ACTION_BITS-1:0] ACT_QUERY = 2'd2;

	// Result status codes
	localparam logic [STATUS_BITS-1:0] STAT_LOAD = 2'd0;
	localparam logic [STATUS_BITS-1:0] STAT_BUILT = 2'd1;
	localparam logic [STATUS_BITS-1:0] STAT_CHUNK = 2'd2;

	// Datapath operations
	typedef logic [4:0] op_t;
	localparam op_t OP_NOP = 5'd0;
	localparam op_t OP_ACCEPT = 5'd1;
	localparam op_t OP_INIT_RD = 5'd2;
	localparam op_t OP_INIT_WR = 5'd3;
	localparam op_t OP_FL_RD = 5'd4;
	localparam op_t OP_FL_LD = 5'd5;
	localparam op_t OP_FL_DEC = 5'd6;
	localparam op_t OP_SD_RD = 5'd7;
	localparam op_t OP_SD_CMP = 5'd8;
	localparam op_t OP_TK_RD = 5'd9;
	localparam op_t OP_TK_LD_A = 5'd10;
	localparam op_t OP_TK_LD_B = 5'd11;
	localparam op_t OP_LNK_A = 5'd12;
	localparam op_t OP_LNK_B = 5'd13;
	localparam op_t OP_SU_CHK = 5'd14;
	localparam op_t OP_SU_CMP = 5'd15;
	localparam op_t OP_BUILT = 5'd16;
	localparam op_t OP_QRY_RD = 5'd17;
	localparam op_t OP_QRY_STEP = 5'd18;
	localparam op_t OP_Q_EMIT = 5'd19;
	localparam op_t OP_R_EMIT = 5'd20;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic child_ok;    // left child of the hole lies inside the heap
		logic sd_stop;     // held entry not above the smaller child
		logic su_top;      // hole at the heap root
		logic su_stop;     // held entry not below its parent
		logic idx_last;    // init sweep at its final entry
		logic idx_zero;    // heapify walk reached the root
		logic cnt_gt1;     // more than one node left to merge
		logic qry_ok;      // tree built and symbol in range
		logic walk_done;   // leaf-to-root walk finished
		logic last_chunk;  // current chunk ends the code
		logic slot_free;   // output register can take a word
	} sts_t;

endpackage

@@ rtl/core/hcb_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_req_if
// Request channel: one load, build or query word per handshake.
// ----------------------------------------------------------------------------
interface hcb_req_if;
	logic valid;
	logic ready;
	logic [hcb_pkg::ACTION_BITS-1:0] action;
	logic [hcb_pkg::SYMBOL_BITS-1:0] symbol;
	logic [hcb_pkg::FREQ_PORT_BITS-1:0] frequency;

	modport source (output valid, output action, output symbol, output frequency,
		input ready);
	modport sink (input valid, input action, input symbol, input frequency,
		output ready);
endinterface

@@ rtl/core/hcb_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_rsp_if
// Response channel: status words and code chunks.
// ----------------------------------------------------------------------------
interface hcb_rsp_if;
	logic valid;
	logic ready;
	logic [hcb_pkg::STATUS_BITS-1:0] status;
	logic [hcb_pkg::CHUNK_BITS-1:0] code_chunk;
	logic [hcb_pkg::CHUNK_IDX_BITS-1:0] chunk_index;
	logic [hcb_pkg::CODE_LEN_BITS-1:0] code_length;
	logic last;

	modport source (output valid, output status, output code_chunk, output chunk_index,
		output code_length, output last, input ready);
	modport sink (input valid, input status, input code_chunk, input chunk_index,
		input code_length, input last, output ready);
endinterface

@@ rtl/core/hcb_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_datapath
// Frequency store, min-heap memory, parent/branch link memory, heap hole
// registers, code shifter and the output register.
// ----------------------------------------------------------------------------
module hcb_datapath #(
	parameter int SYMBOL_COUNT = 256,
	parameter int FREQ_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  hcb_pkg::cmd_t cmd,
	output hcb_pkg::sts_t sts,
	input  logic [hcb_pkg::ACTION_BITS-1:0] action,
	input  logic [hcb_pkg::SYMBOL_BITS-1:0] symbol,
	input  logic [hcb_pkg::FREQ_PORT_BITS-1:0] frequency,
	input  logic out_ready,
	output logic out_valid,
	output logic [hcb_pkg::STATUS_BITS-1:0] out_status,
	output logic [hcb_pkg::CHUNK_BITS-1:0] out_chunk,
	output logic [hcb_pkg::CHUNK_IDX_BITS-1:0] out_index,
	output logic [hcb_pkg::CODE_LEN_BITS-1:0] out_length,
	output logic out_last
);

	localparam int NODES = 2 * SYMBOL_COUNT;
	localparam int NW = $clog2(NODES);
	localparam int HW = $clog2(SYMBOL_COUNT);
	localparam int CW = $clog2(SYMBOL_COUNT + 1);
	localparam int WB = hcb_pkg::WEIGHT_BITS;
	localparam int EW = WB + NW;
	localparam int FLOYD_FIRST = (SYMBOL_COUNT - 1) / 2;
	localparam logic [NW-1:0] ROOT = NW'(NODES - 2);

	// Memories
	logic [FREQ_BITS-1:0] freq_mem [SYMBOL_COUNT];
	logic [EW-1:0] heap_mem [SYMBOL_COUNT];
	logic [NW:0] link_mem [NODES];

	// Control registers
	logic [SYMBOL_COUNT-1:0] fv_q;
	logic tree_ready_q;
	logic ov_q;

	// Payload registers
	logic [hcb_pkg::ACTION_BITS-1:0] act_q;
	logic [FREQ_BITS-1:0] fd_q;
	logic fvr_q;
	logic [CW-1:0] idx_q, pos_q, cnt_q;
	logic [NW-1:0] next_q, node_q;
	logic [EW-1:0] x_q, a_q, b_q, rd0_q, rd1_q;
	logic [NW:0] lk_q;
	logic [hcb_pkg::CODE_BITS-1:0] code_q;
	logic [hcb_pkg::LEN_BITS-1:0] len_q;
	logic [hcb_pkg::CHUNK_IDX_BITS-1:0] chunk_q;
	logic [hcb_pkg::STATUS_BITS-1:0] o_status_q;
	logic [hcb_pkg::CHUNK_BITS-1:0] o_chunk_q;
	logic [hcb_pkg::CHUNK_IDX_BITS-1:0] o_index_q;
	logic [hcb_pkg::CODE_LEN_BITS-1:0] o_length_q;
	logic o_last_q;

	// Combinational helpers
	logic [CW:0] c1, c2, pick_i;
	logic [CW-1:0] par, cnt_m1;
	logic [EW-1:0] pick_e;
	logic rgt, right_ok, sym_ok;
	logic [WB-1:0] w_x, w_rd0, w_rd1, w_pick;
	logic [hcb_pkg::LEN_BITS-1:0] len_m1;
	logic [hcb_pkg::CHUNK_IDX_BITS-1:0] last_idx;
	logic [hcb_pkg::CHUNK_BITS-1:0] chunk_sel;
	logic hp_we;
	logic [HW-1:0] hp_wa, hp_ra0, hp_ra1;
	logic [EW-1:0] hp_wd, init_e;
	logic fwe;

	// Heap navigation
	assign c1 = {pos_q, 1'b1};
	assign c2 = c1 + (CW+1)'(1);
	assign par = (pos_q - CW'(1)) >> 1;
	assign cnt_m1 = cnt_q - CW'(1);
	assign w_x = x_q[EW-1 -: WB];
	assign w_rd0 = rd0_q[EW-1 -: WB];
	assign w_rd1 = rd1_q[EW-1 -: WB];
	assign right_ok = c2 < {1'b0, cnt_q};
	assign rgt = right_ok && (w_rd1 < w_rd0);
	assign pick_e = rgt ? rd1_q : rd0_q;
	assign pick_i = rgt ? c2 : c1;
	assign w_pick = pick_e[EW-1 -: WB];
	assign init_e = {{(WB-FREQ_BITS){1'b0}}, (fvr_q ? fd_q : {FREQ_BITS{1'b0}}), NW'(idx_q)};
	assign sym_ok = {1'b0, symbol} < (hcb_pkg::SYMBOL_BITS+1)'(SYMBOL_COUNT);
	assign fwe = (cmd.op == hcb_pkg::OP_ACCEPT) && (action == hcb_pkg::ACT_LOAD) && sym_ok;

	// Code chunk bookkeeping
	assign len_m1 = len_q - hcb_pkg::LEN_BITS'(1);
	assign last_idx = (len_q == '0) ? '0 : len_m1[7:6];

	always_comb begin
		case (chunk_q)
			2'd0: chunk_sel = code_q[255:192];
			2'd1: chunk_sel = code_q[191:128];
			2'd2: chunk_sel = code_q[127:64];
			default: chunk_sel = code_q[63:0];
		endcase
	end

	// Status toward the controller
	always_comb begin
		sts.child_ok = c1 < {1'b0, cnt_q};
		sts.sd_stop = w_x <= w_pick;
		sts.su_top = pos_q == '0;
		sts.su_stop = !(w_x < w_rd0);
		sts.idx_last = idx_q == CW'(SYMBOL_COUNT - 1);
		sts.idx_zero = idx_q == '0;
		sts.cnt_gt1 = cnt_q > CW'(1);
		sts.qry_ok = tree_ready_q && sym_ok;
		sts.walk_done = (node_q == ROOT) || (len_q == hcb_pkg::LEN_BITS'(SYMBOL_COUNT));
		sts.last_chunk = chunk_q == last_idx;
		sts.slot_free = !ov_q || out_ready;
	end

	// Heap port selection
	always_comb begin
		hp_we = 1'b0;
		hp_wa = '0;
		hp_wd = x_q;
		hp_ra0 = '0;
		hp_ra1 = '0;
		case (cmd.op)
			hcb_pkg::OP_INIT_WR: begin
				hp_we = 1'b1;
				hp_wa = idx_q[HW-1:0];
				hp_wd = init_e;
			end
			hcb_pkg::OP_FL_RD: hp_ra0 = idx_q[HW-1:0];
			hcb_pkg::OP_SD_RD: begin
				if (c1 < {1'b0, cnt_q}) begin
					hp_ra0 = c1[HW-1:0];
					hp_ra1 = c2[HW-1:0];
				end else begin
					hp_we = 1'b1;
					hp_wa = pos_q[HW-1:0];
				end
			end
			hcb_pkg::OP_SD_CMP: begin
				hp_we = 1'b1;
				hp_wa = pos_q[HW-1:0];
				hp_wd = (w_x <= w_pick) ? x_q : pick_e;
			end
			hcb_pkg::OP_TK_RD: hp_ra1 = cnt_m1[HW-1:0];
			hcb_pkg::OP_SU_CHK: begin
				if (pos_q == '0) begin
					hp_we = 1'b1;
				end else begin
					hp_ra0 = par[HW-1:0];
				end
			end
			hcb_pkg::OP_SU_CMP: begin
				hp_we = 1'b1;
				hp_wa = pos_q[HW-1:0];
				hp_wd = (w_x < w_rd0) ? rd0_q : x_q;
			end
			default: hp_we = 1'b0;
		endcase
	end

	// Heap memory
	always_ff @(posedge clk) begin
		if (hp_we) begin
			heap_mem[hp_wa] <= hp_wd;
		end
		rd0_q <= heap_mem[hp_ra0];
		rd1_q <= heap_mem[hp_ra1];
	end

	// Frequency memory
	always_ff @(posedge clk) begin
		if (fwe) begin
			freq_mem[symbol[HW-1:0]] <= frequency[FREQ_BITS-1:0];
		end
		if (cmd.op == hcb_pkg::OP_INIT_RD) begin
			fd_q <= freq_mem[idx_q[HW-1:0]];
			fvr_q <= fv_q[idx_q[HW-1:0]];
		end
	end

	// Parent and branch memory
	always_ff @(posedge clk) begin
		if (cmd.op == hcb_pkg::OP_LNK_A) begin
			link_mem[a_q[NW-1:0]] <= {next_q, 1'b0};
		end else if (cmd.op == hcb_pkg::OP_LNK_B) begin
			link_mem[b_q[NW-1:0]] <= {next_q, 1'b1};
		end
		if (cmd.op == hcb_pkg::OP_QRY_RD) begin
			lk_q <= link_mem[node_q];
		end
	end

	// Control state: frequency valid bits, tree flag, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_q <= '0;
			tree_ready_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (fwe) begin
				fv_q[symbol[HW-1:0]] <= 1'b1;
			end
			if (cmd.op == hcb_pkg::OP_BUILT) begin
				tree_ready_q <= 1'b1;
			end
			if (cmd.op == hcb_pkg::OP_Q_EMIT || cmd.op == hcb_pkg::OP_R_EMIT) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			hcb_pkg::OP_ACCEPT: begin
				act_q <= action;
				node_q <= NW'(symbol);
				len_q <= '0;
				code_q <= '0;
				chunk_q <= '0;
				idx_q <= '0;
			end
			hcb_pkg::OP_INIT_WR: begin
				if (idx_q == CW'(SYMBOL_COUNT - 1)) begin
					cnt_q <= CW'(SYMBOL_COUNT);
					idx_q <= CW'(FLOYD_FIRST);
					next_q <= NW'(SYMBOL_COUNT);
				end else begin
					idx_q <= idx_q + CW'(1);
				end
			end
			hcb_pkg::OP_FL_LD: begin
				x_q <= rd0_q;
				pos_q <= idx_q;
			end
			hcb_pkg::OP_FL_DEC: idx_q <= idx_q - CW'(1);
			hcb_pkg::OP_SD_CMP: begin
				if (!(w_x <= w_pick)) begin
					pos_q <= pick_i[CW-1:0];
				end
			end
			hcb_pkg::OP_TK_LD_A: begin
				a_q <= rd0_q;
				x_q <= rd1_q;
				cnt_q <= cnt_m1;
				pos_q <= '0;
			end
			hcb_pkg::OP_TK_LD_B: begin
				b_q <= rd0_q;
				x_q <= rd1_q;
				cnt_q <= cnt_m1;
				pos_q <= '0;
			end
			hcb_pkg::OP_LNK_B: begin
				x_q <= {a_q[EW-1 -: WB] + b_q[EW-1 -: WB], next_q};
				pos_q <= cnt_q;
				cnt_q <= cnt_q + CW'(1);
				next_q <= next_q + NW'(1);
			end
			hcb_pkg::OP_SU_CMP: begin
				if (w_x < w_rd0) begin
					pos_q <= par;
				end
			end
			hcb_pkg::OP_QRY_STEP: begin
				code_q <= {lk_q[0], code_q[hcb_pkg::CODE_BITS-1:1]};
				node_q <= lk_q[NW:1];
				len_q <= len_q + hcb_pkg::LEN_BITS'(1);
			end
			hcb_pkg::OP_Q_EMIT: chunk_q <= chunk_q + hcb_pkg::CHUNK_IDX_BITS'(1);
			default: ;
		endcase
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.op == hcb_pkg::OP_Q_EMIT) begin
			o_status_q <= hcb_pkg::STAT_CHUNK;
			o_chunk_q <= chunk_sel;
			o_index_q <= chunk_q;
			o_length_q <= len_q[hcb_pkg::CODE_LEN_BITS-1:0];
			o_last_q <= chunk_q == last_idx;
		end else if (cmd.op == hcb_pkg::OP_R_EMIT) begin
			o_status_q <= (act_q == hcb_pkg::ACT_BUILD) ? hcb_pkg::STAT_BUILT
				: hcb_pkg::STAT_LOAD;
			o_chunk_q <= '0;
			o_index_q <= '0;
			o_length_q <= '0;
			o_last_q <= 1'b1;
		end
	end

	assign out_valid = ov_q;
	assign out_status = o_status_q;
	assign out_chunk = o_chunk_q;
	assign out_index = o_index_q;
	assign out_length = o_length_q;
	assign out_last = o_last_q;

endmodule

@@ rtl/core/hcb_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_ctrl
// Sequencer: load handling, heap fill, heapify, merge loop with extract-min
// and insert, leaf-to-root code walk and chunk emission.
// ----------------------------------------------------------------------------
module hcb_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [hcb_pkg::ACTION_BITS-1:0] in_action,
	output logic in_ready,
	input  hcb_pkg::sts_t sts,
	output hcb_pkg::cmd_t cmd
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_INIT_RD = 5'd1;
	localparam logic [4:0] S_INIT_WR = 5'd2;
	localparam logic [4:0] S_FL_RD = 5'd3;
	localparam logic [4:0] S_FL_LD = 5'd4;
	localparam logic [4:0] S_SD_RD = 5'd5;
	localparam logic [4:0] S_SD_CMP = 5'd6;
	localparam logic [4:0] S_FL_NEXT = 5'd7;
	localparam logic [4:0] S_TK_RD = 5'd8;
	localparam logic [4:0] S_TK_LD = 5'd9;
	localparam logic [4:0] S_LNK_A = 5'd10;
	localparam logic [4:0] S_LNK_B = 5'd11;
	localparam logic [4:0] S_SU_CHK = 5'd12;
	localparam logic [4:0] S_SU_CMP = 5'd13;
	localparam logic [4:0] S_MRG_CHK = 5'd14;
	localparam logic [4:0] S_QRY_CHK = 5'd15;
	localparam logic [4:0] S_QRY_STEP = 5'd16;
	localparam logic [4:0] S_Q_OUT = 5'd17;
	localparam logic [4:0] S_RESP = 5'd18;

	// Owner of the current sift-down pass
	localparam logic [1:0] CTX_FLOYD = 2'd0;
	localparam logic [1:0] CTX_TAKE_A = 2'd1;
	localparam logic [1:0] CTX_TAKE_B = 2'd2;

	logic [4:0] state_q, state_d;
	logic [1:0] ctx_q, ctx_d;
	logic [4:0] sd_ret;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ctx_q <= CTX_FLOYD;
		end else begin
			state_q <= state_d;
			ctx_q <= ctx_d;
		end
	end

	// Return point once a sift-down pass ends
	always_comb begin
		case (ctx_q)
			CTX_FLOYD: sd_ret = S_FL_NEXT;
			CTX_TAKE_A: sd_ret = S_TK_RD;
			default: sd_ret = S_LNK_A;
		endcase
	end

	always_comb begin
		state_d = state_q;
		ctx_d = ctx_q;
		cmd.op = hcb_pkg::OP_NOP;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = hcb_pkg::OP_ACCEPT;
					case (in_action)
						hcb_pkg::ACT_LOAD: state_d = S_RESP;
						hcb_pkg::ACT_BUILD: state_d = S_INIT_RD;
						hcb_pkg::ACT_QUERY: state_d = sts.qry_ok ? S_QRY_CHK : S_Q_OUT;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_INIT_RD: begin
				cmd.op = hcb_pkg::OP_INIT_RD;
				state_d = S_INIT_WR;
			end
			S_INIT_WR: begin
				cmd.op = hcb_pkg::OP_INIT_WR;
				state_d = sts.idx_last ? S_FL_RD : S_INIT_RD;
			end
			S_FL_RD: begin
				cmd.op = hcb_pkg::OP_FL_RD;
				state_d = S_FL_LD;
			end
			S_FL_LD: begin
				cmd.op = hcb_pkg::OP_FL_LD;
				ctx_d = CTX_FLOYD;
				state_d = S_SD_RD;
			end
			S_SD_RD: begin
				cmd.op = hcb_pkg::OP_SD_RD;
				state_d = sts.child_ok ? S_SD_CMP : sd_ret;
				if (!sts.child_ok && ctx_q == CTX_TAKE_A) begin
					ctx_d = CTX_TAKE_B;
				end
			end
			S_SD_CMP: begin
				cmd.op = hcb_pkg::OP_SD_CMP;
				state_d = sts.sd_stop ? sd_ret : S_SD_RD;
				if (sts.sd_stop && ctx_q == CTX_TAKE_A) begin
					ctx_d = CTX_TAKE_B;
				end
			end
			S_FL_NEXT: begin
				if (sts.idx_zero) begin
					state_d = S_MRG_CHK;
				end else begin
					cmd.op = hcb_pkg::OP_FL_DEC;
					state_d = S_FL_RD;
				end
			end
			S_TK_RD: begin
				cmd.op = hcb_pkg::OP_TK_RD;
				state_d = S_TK_LD;
			end
			S_TK_LD: begin
				cmd.op = (ctx_q == CTX_TAKE_A) ? hcb_pkg::OP_TK_LD_A : hcb_pkg::OP_TK_LD_B;
				state_d = S_SD_RD;
			end
			S_LNK_A: begin
				cmd.op = hcb_pkg::OP_LNK_A;
				state_d = S_LNK_B;
			end
			S_LNK_B: begin
				cmd.op = hcb_pkg::OP_LNK_B;
				state_d = S_SU_CHK;
			end
			S_SU_CHK: begin
				cmd.op = hcb_pkg::OP_SU_CHK;
				state_d = sts.su_top ? S_MRG_CHK : S_SU_CMP;
			end
			S_SU_CMP: begin
				cmd.op = hcb_pkg::OP_SU_CMP;
				state_d = sts.su_stop ? S_MRG_CHK : S_SU_CHK;
			end
			S_MRG_CHK: begin
				if (sts.cnt_gt1) begin
					ctx_d = CTX_TAKE_A;
					state_d = S_TK_RD;
				end else begin
					cmd.op = hcb_pkg::OP_BUILT;
					state_d = S_RESP;
				end
			end
			S_QRY_CHK: begin
				if (sts.walk_done) begin
					state_d = S_Q_OUT;
				end else begin
					cmd.op = hcb_pkg::OP_QRY_RD;
					state_d = S_QRY_STEP;
				end
			end
			S_QRY_STEP: begin
				cmd.op = hcb_pkg::OP_QRY_STEP;
				state_d = S_QRY_CHK;
			end
			S_Q_OUT: begin
				if (sts.slot_free) begin
					cmd.op = hcb_pkg::OP_Q_EMIT;
					state_d = sts.last_chunk ? S_IDLE : S_Q_OUT;
				end
			end
			S_RESP: begin
				if (sts.slot_free) begin
					cmd.op = hcb_pkg::OP_R_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

@@ rtl/core/huffman_code_builder_top.sv @@
`timescale 1ns / 1ps
// Load: accepted in idle; the status word is registered once the output slot is free.
// Build: heap fill over all N entries, then a read and a compare state for every sift
//   step of heapify and of the N-1 merges (single heap memory write port).
// Query: read and shift per tree level, then one chunk per cycle while rsp.ready holds.
// Reset clears control state and the frequency valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
// huffman_code_builder_top
// Huffman code builder: frequency loads, heap-based tree build and per-symbol
// code queries returned in 64-bit chunks.
// ----------------------------------------------------------------------------
module huffman_code_builder_top #(
	parameter int SYMBOL_COUNT = 256,
	parameter int FREQ_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	hcb_req_if.sink req,
	hcb_rsp_if.source rsp
);

	hcb_pkg::cmd_t cmd;
	hcb_pkg::sts_t sts;

	hcb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_action (req.action),
		.in_ready  (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	hcb_datapath #(
		.SYMBOL_COUNT (SYMBOL_COUNT),
		.FREQ_BITS    (FREQ_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.action     (req.action),
		.symbol     (req.symbol),
		.frequency  (req.frequency),
		.out_ready  (rsp.ready),
		.out_valid  (rsp.valid),
		.out_status (rsp.status),
		.out_chunk  (rsp.code_chunk),
		.out_index  (rsp.chunk_index),
		.out_length (rsp.code_length),
		.out_last   (rsp.last)
	);

endmodule
